// File: src/bptt_pkg.sv
// Package for the bank page table translator: command codes, register indexes,
// stream field positions and fixed constants. No dependencies.

package bptt_pkg;

    localparam logic [2:0] CMD_MAP_PRG   = 3'd0;
    localparam logic [2:0] CMD_MAP_CHR   = 3'd1;
    localparam logic [2:0] CMD_CPU_READ  = 3'd2;
    localparam logic [2:0] CMD_CPU_WRITE = 3'd3;
    localparam logic [2:0] CMD_PPU_READ  = 3'd4;
    localparam logic [2:0] CMD_PPU_WRITE = 3'd5;

    localparam logic [2:0] REG_PRG_ROM_SIZE_LOG2   = 3'd0;
    localparam logic [2:0] REG_CHR_ROM_SIZE_LOG2   = 3'd1;
    localparam logic [2:0] REG_CHR_IS_RAM          = 3'd2;
    localparam logic [2:0] REG_PRG_SLOT_PAGES_LOG2 = 3'd3;
    localparam logic [2:0] REG_CHR_SLOT_PAGES_LOG2 = 3'd4;

    localparam logic [4:0] RST_PRG_ROM_SIZE_LOG2   = 5'd15;
    localparam logic [4:0] RST_CHR_ROM_SIZE_LOG2   = 5'd13;
    localparam logic       RST_CHR_IS_RAM          = 1'b0;
    localparam logic [2:0] RST_PRG_SLOT_PAGES_LOG2 = 3'd6;
    localparam logic [2:0] RST_CHR_SLOT_PAGES_LOG2 = 3'd5;

    localparam logic [15:0] PRG_BASE      = 16'h8000;
    localparam logic [15:0] PPU_ADDR_MASK = 16'h1FFF;

    localparam int CHR_PAGES = 32;
    localparam int CHR_IDX_W = 5;

    // input tdata layout
    localparam int IN_TDATA_W = 72;
    localparam int RUN_LSB    = 0;
    localparam int SLOT_LSB   = 2;
    localparam int BANK_LSB   = 10;
    localparam int BOFF_LSB   = 26;
    localparam int ADDR_LSB   = 48;
    localparam int WDATA_LSB  = 64;

    // output tdata layout
    localparam int OUT_TDATA_W = 32;

endpackage

// File: src/bank_page_table_translator_unit.sv
// Top level of the bank page table translator: page tables in two synchronous
// memories, map sequencer, lookup and result register. Uses bptt_pkg.

// For a CPU or PPU access the page table entry is read at the transfer into
// the block, and the translated result is registered from the table read data
// once the output register is free. A new item is taken only in the idle
// state, after the last item has been passed to the output register. A map
// command writes one page table entry per cycle through the single write port
// of the selected table, run length times slot pages entries, cut at the table
// end. Each item, map commands included, yields one result transfer; a map
// result has every field zero. Valid bits in flip-flops mark mapped pages, so
// the tables need no clearing after reset.

module bank_page_table_translator_unit #(
    parameter int ROM_ADDR_BITS = 22,
    parameter int PRG_PAGES     = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command
    input  logic [2:0]  s_tuser,
    // run_log2, slot, bank, bank_offset, address, write_data
    input  logic [bptt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // target
    output logic [0:0]  m_tuser,
    // rom_offset, mapped, write_enable, write_data_out
    output logic [bptt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RA        = ROM_ADDR_BITS;
    localparam int PRG_IDX_W = $clog2(PRG_PAGES);
    localparam int CHR_W     = bptt_pkg::CHR_IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [RA-1:0] size_mask(input logic [4:0] lg);
        logic [RA-1:0] m;
        m = '0;
        for (int b = 0; b < RA; b++) begin
            m[b] = (b < int'(lg));
        end
        return m;
    endfunction

    // configuration
    logic [4:0] prg_size_reg;
    logic [4:0] chr_size_reg;
    logic       chr_ram_reg;
    logic [2:0] prg_spl_reg;
    logic [2:0] chr_spl_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_size_reg <= bptt_pkg::RST_PRG_ROM_SIZE_LOG2;
            chr_size_reg <= bptt_pkg::RST_CHR_ROM_SIZE_LOG2;
            chr_ram_reg  <= bptt_pkg::RST_CHR_IS_RAM;
            prg_spl_reg  <= bptt_pkg::RST_PRG_SLOT_PAGES_LOG2;
            chr_spl_reg  <= bptt_pkg::RST_CHR_SLOT_PAGES_LOG2;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bptt_pkg::REG_PRG_ROM_SIZE_LOG2:   prg_size_reg <= pwdata[4:0];
                bptt_pkg::REG_CHR_ROM_SIZE_LOG2:   chr_size_reg <= pwdata[4:0];
                bptt_pkg::REG_CHR_IS_RAM:          chr_ram_reg  <= pwdata[0];
                bptt_pkg::REG_PRG_SLOT_PAGES_LOG2: prg_spl_reg  <= pwdata[2:0];
                bptt_pkg::REG_CHR_SLOT_PAGES_LOG2: chr_spl_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bptt_pkg::REG_PRG_ROM_SIZE_LOG2:   prdata = {27'd0, prg_size_reg};
            bptt_pkg::REG_CHR_ROM_SIZE_LOG2:   prdata = {27'd0, chr_size_reg};
            bptt_pkg::REG_CHR_IS_RAM:          prdata = {31'd0, chr_ram_reg};
            bptt_pkg::REG_PRG_SLOT_PAGES_LOG2: prdata = {29'd0, prg_spl_reg};
            bptt_pkg::REG_CHR_SLOT_PAGES_LOG2: prdata = {29'd0, chr_spl_reg};
            default:                           prdata = 32'd0;
        endcase
    end

    // input fields
    logic [1:0]  in_run;
    logic [7:0]  in_slot;
    logic [15:0] in_bank;
    logic [21:0] in_boff;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    logic [2:0]  in_cmd;

    assign in_cmd   = s_tuser;
    assign in_run   = s_tdata[bptt_pkg::RUN_LSB +: 2];
    assign in_slot  = s_tdata[bptt_pkg::SLOT_LSB +: 8];
    assign in_bank  = s_tdata[bptt_pkg::BANK_LSB +: 16];
    assign in_boff  = s_tdata[bptt_pkg::BOFF_LSB +: 22];
    assign in_addr  = s_tdata[bptt_pkg::ADDR_LSB +: 16];
    assign in_wdata = s_tdata[bptt_pkg::WDATA_LSB +: 8];

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // access address decode
    logic [15:0]          prg_rel;
    logic                 prg_in_range;
    logic [PRG_IDX_W-1:0] prg_ridx;
    logic [15:0]          chr_a;
    logic [CHR_W-1:0]     chr_ridx;

    assign prg_rel      = in_addr - bptt_pkg::PRG_BASE;
    assign prg_in_range = (in_addr >= bptt_pkg::PRG_BASE) && (prg_rel[15:8] < 8'(PRG_PAGES));
    assign prg_ridx     = prg_rel[8 +: PRG_IDX_W];
    assign chr_a        = in_addr & bptt_pkg::PPU_ADDR_MASK;
    assign chr_ridx     = chr_a[8 +: CHR_W];

    // tables
    logic [RA-1:0]            prg_mem [PRG_PAGES];
    logic [RA:0]              chr_mem [bptt_pkg::CHR_PAGES];
    logic [PRG_PAGES-1:0]     prg_valid_reg;
    logic [bptt_pkg::CHR_PAGES-1:0] chr_valid_reg;
    logic [RA-1:0]            prg_rd_reg;
    logic [RA:0]              chr_rd_reg;

    // lookup context
    logic [2:0] cmd_reg;
    logic       hit_reg;
    logic [7:0] lo_reg;
    logic [7:0] wdata_reg;

    // fill sequencer
    logic          fill_chr_reg;
    logic [2:0]    fill_pl_reg;
    logic [17:0]   fill_start_reg;
    logic [10:0]   fill_j_reg;
    logic [10:0]   fill_total_reg;
    logic [15:0]   fill_bank_reg;
    logic [21:0]   fill_boff_reg;
    logic [RA-1:0] fill_mask_reg;
    logic          fill_wr_reg;

    logic [2:0]    map_pl;
    logic [18:0]   fill_idx;
    logic          fill_end;
    logic          fill_we;
    logic [2:0]    fill_i;
    logic [6:0]    fill_k;
    logic [15:0]   fill_b;
    logic [RA-1:0] fill_base;
    logic [RA-1:0] fill_off;

    assign map_pl   = (in_cmd == bptt_pkg::CMD_MAP_CHR) ? chr_spl_reg : prg_spl_reg;
    assign fill_idx = {1'b0, fill_start_reg} + 19'(fill_j_reg);
    assign fill_end = (fill_j_reg == fill_total_reg) ||
                      (fill_idx >= (fill_chr_reg ? 19'(bptt_pkg::CHR_PAGES) : 19'(PRG_PAGES)));
    assign fill_we  = (state_reg == ST_FILL) && !fill_end;
    assign fill_i   = 3'(fill_j_reg >> fill_pl_reg);
    assign fill_k   = 7'(fill_j_reg & ((11'd1 << fill_pl_reg) - 11'd1));
    assign fill_b   = fill_bank_reg + 16'(fill_i);
    assign fill_base = RA'(31'({fill_b, 8'h00}) << fill_pl_reg);
    assign fill_off = (fill_base + RA'(fill_boff_reg) + RA'({fill_k, 8'h00})) & fill_mask_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            prg_rd_reg <= prg_mem[prg_ridx];
            chr_rd_reg <= chr_mem[chr_ridx];
        end
        if (fill_we && !fill_chr_reg) begin
            prg_mem[fill_idx[PRG_IDX_W-1:0]] <= fill_off;
        end
        if (fill_we && fill_chr_reg) begin
            chr_mem[fill_idx[CHR_W-1:0]] <= {fill_wr_reg, fill_off};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_valid_reg <= '0;
            chr_valid_reg <= '0;
        end else if (fill_we) begin
            if (fill_chr_reg) begin
                chr_valid_reg[fill_idx[CHR_W-1:0]] <= 1'b1;
            end else begin
                prg_valid_reg[fill_idx[PRG_IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg        <= in_cmd;
            lo_reg         <= in_addr[7:0];
            wdata_reg      <= in_wdata;
            hit_reg        <= ((in_cmd == bptt_pkg::CMD_CPU_READ ||
                                in_cmd == bptt_pkg::CMD_CPU_WRITE) &&
                               prg_in_range && prg_valid_reg[prg_ridx]) ||
                              ((in_cmd == bptt_pkg::CMD_PPU_READ ||
                                in_cmd == bptt_pkg::CMD_PPU_WRITE) &&
                               chr_valid_reg[chr_ridx]);
            fill_chr_reg   <= (in_cmd == bptt_pkg::CMD_MAP_CHR);
            fill_pl_reg    <= map_pl;
            fill_start_reg <= (18'(in_slot) << in_run) << map_pl;
            fill_total_reg <= 11'd1 << (4'(in_run) + 4'(map_pl));
            fill_bank_reg  <= in_bank;
            fill_boff_reg  <= in_boff;
            fill_mask_reg  <= size_mask((in_cmd == bptt_pkg::CMD_MAP_CHR) ?
                                        chr_size_reg : prg_size_reg);
            fill_wr_reg    <= (in_cmd == bptt_pkg::CMD_MAP_CHR) && chr_ram_reg;
        end
    end

    // fill counter
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            fill_j_reg <= '0;
        end else if (fill_we) begin
            fill_j_reg <= fill_j_reg + 11'd1;
        end
    end

    // lookup result
    logic           is_ppu;
    logic [RA-1:0]  look_mask;
    logic [RA-1:0]  look_sum;
    logic [21:0]    look_off;
    logic           look_we;
    logic           out_free;

    assign is_ppu    = (cmd_reg == bptt_pkg::CMD_PPU_READ) ||
                       (cmd_reg == bptt_pkg::CMD_PPU_WRITE);
    assign look_mask = size_mask(is_ppu ? chr_size_reg : prg_size_reg);
    assign look_sum  = ((is_ppu ? chr_rd_reg[RA-1:0] : prg_rd_reg) + RA'(lo_reg)) & look_mask;
    assign look_off  = hit_reg ? 22'(look_sum) : 22'd0;
    assign look_we   = hit_reg && (cmd_reg == bptt_pkg::CMD_PPU_WRITE) && chr_rd_reg[RA];
    assign out_free  = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    priority if (in_cmd == bptt_pkg::CMD_MAP_PRG ||
                                 in_cmd == bptt_pkg::CMD_MAP_CHR) begin
                        state_next = ST_FILL;
                    end else if (in_cmd == bptt_pkg::CMD_CPU_READ ||
                                 in_cmd == bptt_pkg::CMD_CPU_WRITE ||
                                 in_cmd == bptt_pkg::CMD_PPU_READ ||
                                 in_cmd == bptt_pkg::CMD_PPU_WRITE) begin
                        state_next = ST_LOOK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOOK: if (out_free) state_next = ST_IDLE;
            ST_FILL: if (fill_end) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic m_tvalid_reg;
    logic [bptt_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_LOOK || state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK && out_free) begin
            m_tdata_reg <= {(look_we ? wdata_reg : 8'd0), look_we, hit_reg, look_off};
            m_tuser_reg <= is_ppu;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= '0;
            m_tuser_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
